// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the page table walker modules.
// Each macro expands to one labeled concurrent assertion clocked on the given clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gptw_pkg.sv =====
// Package for the guest page table walker: field widths, codes, word types and
// the shared entry-index and result-building functions. Depends on nothing.
package gptw_pkg;

  localparam int unsigned VA_W    = 48;
  localparam int unsigned ROOT_W  = 52;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned FRAME_W = 40;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned LVL_W   = 3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PAGING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_ROOT  = 2'd1;

  localparam logic [1:0] MODE_REAL = 2'd0;
  localparam logic [1:0] MODE_TWO  = 2'd1;
  localparam logic [1:0] MODE_PAE  = 2'd2;
  localparam logic [1:0] MODE_LONG = 2'd3;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 3'd4;

  localparam logic [31:0] BIG_MASK = 32'h001F_E000;
  localparam logic [6:0]  PAE_SLOT_MASK = 7'd127;
  localparam int unsigned PAE_SLOT_SPAN = 4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_RESP  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    KIND_REQ    = 1'b0,
    KIND_RESULT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ROOT_W-1:0] root;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [FRAME_W-1:0] table_frame;
    logic [IDX_W-1:0]   entry_index;
    logic               entry_wide;
    logic [LVL_W-1:0]   walk_level;
    logic [FRAME_W-1:0] guest_frame;
    logic               fault;
    logic               too_large;
  } res_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [VA_W-1:0]    va;
    logic [ENTRY_W-1:0] entry;
    logic               frame_valid;
    res_t               start_res;
  } item_t;

  // Eight-byte word index of the entry for a given level of the walk.
  function automatic logic [IDX_W-1:0] req_index(logic [1:0] mode, logic [ROOT_W-1:0] root,
                                                  logic [VA_W-1:0] va, logic [LVL_W-1:0] lvl);
    logic [9:0]       dword_idx;
    logic [6:0]       slot;
    logic [IDX_W-1:0] idx;
    dword_idx = (lvl == 3'd2) ? va[31:22] : va[21:12];
    slot      = root[11:5] & PAE_SLOT_MASK;
    idx       = '0;
    if (mode == MODE_TWO) begin
      idx = dword_idx[9:1];
    end else if (mode == MODE_PAE && lvl == 3'd3) begin
      idx = IDX_W'(32'(slot) * PAE_SLOT_SPAN) + IDX_W'(va[31:30]);
    end else begin
      case (lvl)
        3'd1:    idx = va[20:12];
        3'd2:    idx = va[29:21];
        3'd3:    idx = va[38:30];
        3'd4:    idx = va[47:39];
        default: idx = '0;
      endcase
    end
    return idx;
  endfunction

  function automatic res_t make_request(logic [FRAME_W-1:0] frame, logic [IDX_W-1:0] idx,
                                        logic [LVL_W-1:0] lvl);
    res_t r;
    r             = '0;
    r.kind        = KIND_REQ;
    r.table_frame = frame;
    r.entry_index = idx;
    r.entry_wide  = 1'b1;
    r.walk_level  = lvl;
    return r;
  endfunction

  function automatic res_t make_result(logic [FRAME_W-1:0] gfn, logic flt, logic big);
    res_t r;
    r             = '0;
    r.kind        = KIND_RESULT;
    r.guest_frame = flt ? '0 : gfn;
    r.fault       = flt;
    r.too_large   = big;
    return r;
  endfunction

endpackage

// ===== rtl/guest_page_table_walker_top.sv =====
// Top level of the guest page table walker: configuration registers, front end,
// word queue and back end. Uses gptw_pkg, gptw_front, gptw_fifo and gptw_back.
//
// Usage: the input channel (in_valid/in_ready) carries one word per handshake,
// either a translate command (command 0, virt_addr) or a table entry response
// (command 1, entry_data, frame_valid). The output channel (out_valid/out_ready)
// carries at most one word per input word: a table read request (kind 0) or a
// final translation (kind 1). A response that arrives while no walk is pending
// produces no output word. The configuration channel (cfg_valid/cfg_ready)
// writes paging_mode (index 0) or table_root (index 1); it is always ready and
// should only be used while the walker is idle.
// The queue captures each accepted word; the back end pops it and registers its result
// in the output register, where out_valid rises.
// Throughput, set by the back end, is one word per cycle while out_ready stays high;
// the back end resolves one entry per cycle with masking, shifting and a level step.
// Reset clears the configuration registers to real mode with a zero root, ends
// any pending walk and empties the queue and the output register.
// When the receiver stalls, the output word holds, the back end stops, and the
// queue fills; in_ready falls once both queue entries are occupied.
module guest_page_table_walker_top #(
  parameter int unsigned VADDR_BITS = 48,
  parameter int unsigned PADDR_BITS = 52
) (
  input  logic                               clk,
  input  logic                               rst,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gptw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gptw_pkg::ROOT_W-1:0]        cfg_data,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [gptw_pkg::VA_W-1:0]          virt_addr,
  input  logic [gptw_pkg::ENTRY_W-1:0]       entry_data,
  input  logic                               frame_valid,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               kind,
  output logic [gptw_pkg::FRAME_W-1:0]       table_frame,
  output logic [gptw_pkg::IDX_W-1:0]         entry_index,
  output logic                               entry_wide,
  output logic [gptw_pkg::LVL_W-1:0]         walk_level,
  output logic [gptw_pkg::FRAME_W-1:0]       guest_frame,
  output logic                               fault,
  output logic                               too_large
);

  // Configuration registers; the back end reads them directly, so a mode change
  // between responses takes effect on the next response.
  gptw_pkg::cfg_t  cfg;

  gptw_pkg::item_t push_item;
  gptw_pkg::item_t pop_item;
  gptw_pkg::res_t  out_res;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gptw_pkg::REG_PAGING_MODE: cfg.mode <= cfg_data[1:0];
        gptw_pkg::REG_TABLE_ROOT:  cfg.root <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: masks the address and prepares the first step of a walk.
  gptw_front #(
    .VADDR_BITS (VADDR_BITS)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .virt_addr   (virt_addr),
    .entry_data  (entry_data),
    .frame_valid (frame_valid),
    .cfg         (cfg),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  // The queue lets the front keep accepting while the back waits on the receiver.
  gptw_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_item  (push_item),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (pop_item)
  );

  // Back end: owns the walk state and the output register.
  gptw_back #(
    .PADDR_BITS (PADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind        = out_res.kind;
  assign table_frame = out_res.table_frame;
  assign entry_index = out_res.entry_index;
  assign entry_wide  = out_res.entry_wide;
  assign walk_level  = out_res.walk_level;
  assign guest_frame = out_res.guest_frame;
  assign fault       = out_res.fault;
  assign too_large   = out_res.too_large;

endmodule

// ===== rtl/gptw_front.sv =====
// Front end of the guest page table walker: accepts input words, masks the
// address and prepares the outcome of a translate command. Uses gptw_pkg.
module gptw_front #(
  parameter int unsigned VADDR_BITS = 48
) (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [gptw_pkg::VA_W-1:0]       virt_addr,
  input  logic [gptw_pkg::ENTRY_W-1:0]    entry_data,
  input  logic                            frame_valid,
  input  gptw_pkg::cfg_t                  cfg,
  input  logic                            q_full,
  output logic                            q_push,
  output gptw_pkg::item_t                 q_item
);

  localparam logic [63:0] VA_MASK = (64'd1 << VADDR_BITS) - 64'd1;

  logic [gptw_pkg::VA_W-1:0]  va;
  logic [gptw_pkg::LVL_W-1:0] top_level;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;
  assign va        = virt_addr & VA_MASK[gptw_pkg::VA_W-1:0];
  assign top_level = {1'b0, cfg.mode} + 3'd1;

  always_comb begin
    q_item             = '0;
    q_item.cmd         = gptw_pkg::cmd_t'(command);
    q_item.va          = va;
    q_item.entry       = entry_data;
    q_item.frame_valid = frame_valid;
    // Real mode answers at once; otherwise the walk opens at the root table.
    if (cfg.mode == gptw_pkg::MODE_REAL) begin
      q_item.start_res = gptw_pkg::make_result(gptw_pkg::FRAME_W'(va[gptw_pkg::VA_W-1:12]),
                                               1'b0, 1'b0);
    end else begin
      q_item.start_res = gptw_pkg::make_request(cfg.root[51:12],
                           gptw_pkg::req_index(cfg.mode, cfg.root, va, top_level), top_level);
    end
  end

endmodule

// ===== rtl/gptw_fifo.sv =====
// Short queue of classified words between the front and back of the walker.
// Uses gptw_pkg for the word type and depth; includes assert_macros.svh.
`include "assert_macros.svh"

module gptw_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gptw_pkg::item_t wr_item,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output gptw_pkg::item_t rd_item
);

  gptw_pkg::item_t                   mem [gptw_pkg::QUEUE_DEPTH];
  logic [gptw_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [gptw_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [gptw_pkg::QUEUE_CNT_W-1:0]  count;

  assign full     = (count == gptw_pkg::QUEUE_CNT_W'(gptw_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == gptw_pkg::QUEUE_PTR_W'(gptw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == gptw_pkg::QUEUE_PTR_W'(gptw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + gptw_pkg::QUEUE_CNT_W'(push) - gptw_pkg::QUEUE_CNT_W'(pop);
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst, push, !full || pop, "queue written while full")
  `ASSERT_IMPL(a_no_underflow, clk, rst, pop, rd_valid, "queue read while empty")

endmodule

// ===== rtl/gptw_back.sv =====
// Back end of the guest page table walker: holds the walk state, consumes
// queued words and drives the output register. Uses gptw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gptw_back #(
  parameter int unsigned PADDR_BITS = 52
) (
  input  logic            clk,
  input  logic            rst,
  input  gptw_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  gptw_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output gptw_pkg::res_t  out_res
);

  localparam logic [63:0] PA_MASK = ((64'd1 << PADDR_BITS) - 64'd1) & ~64'hFFF;

  logic                            busy;
  logic [gptw_pkg::LVL_W-1:0]      level;
  logic [gptw_pkg::VA_W-1:0]       held;

  logic                            busy_next;
  logic [gptw_pkg::LVL_W-1:0]      level_next;
  logic [gptw_pkg::VA_W-1:0]       held_next;
  logic                            produce;
  gptw_pkg::res_t                  res;

  logic                            level_bad;
  logic                            half;
  logic [31:0]                     e32;
  logic [63:0]                     pa;
  logic [gptw_pkg::FRAME_W-1:0]    pframe;
  logic                            present;
  logic                            is_large;

  assign q_pop     = q_valid && (!out_valid || out_ready);
  assign level_bad = (cfg.mode == gptw_pkg::MODE_REAL) || (level == '0) ||
                     (level > ({1'b0, cfg.mode} + 3'd1));
  // Two-level entries are four bytes; pick the half of the eight-byte word.
  assign half      = (level == 3'd2) ? held[22] : held[12];
  assign e32       = half ? q_item.entry[63:32] : q_item.entry[31:0];
  assign pa        = q_item.entry & PA_MASK;
  assign pframe    = pa[51:12];
  assign present   = (cfg.mode == gptw_pkg::MODE_TWO) ? e32[0] : q_item.entry[0];
  assign is_large  = (cfg.mode == gptw_pkg::MODE_TWO) ? e32[7] : q_item.entry[7];

  always_comb begin
    produce = 1'b0;
    res     = '0;
    held_next = held;
    if (q_item.cmd == gptw_pkg::CMD_START) begin
      produce   = 1'b1;
      held_next = q_item.va;
      res       = q_item.start_res;
    end else if (busy) begin
      produce = 1'b1;
      if (level_bad || !q_item.frame_valid) begin
        res = gptw_pkg::make_result('0, 1'b1, 1'b0);
      end else if (cfg.mode == gptw_pkg::MODE_TWO) begin
        if (level == 3'd2 && is_large) begin
          res = gptw_pkg::make_result(gptw_pkg::FRAME_W'({e32[31:22], held[21:12]}),
                                      !present, |(e32 & gptw_pkg::BIG_MASK));
        end else if (level == 3'd1) begin
          res = gptw_pkg::make_result(gptw_pkg::FRAME_W'(e32[31:12]), !present, 1'b0);
        end else if (!present) begin
          res = gptw_pkg::make_result('0, 1'b1, 1'b0);
        end else begin
          res = gptw_pkg::make_request(gptw_pkg::FRAME_W'(e32[31:12]),
                  gptw_pkg::req_index(cfg.mode, cfg.root, held, 3'd1), 3'd1);
        end
      end else begin
        if (level == 3'd2 && is_large) begin
          res = gptw_pkg::make_result({pframe[gptw_pkg::FRAME_W-1:9], held[20:12]},
                                      !present, 1'b0);
        end else if (level == 3'd1) begin
          res = gptw_pkg::make_result(pframe, !present, 1'b0);
        end else if (!present) begin
          res = gptw_pkg::make_result('0, 1'b1, 1'b0);
        end else begin
          res = gptw_pkg::make_request(pframe,
                  gptw_pkg::req_index(cfg.mode, cfg.root, held, level - 3'd1), level - 3'd1);
        end
      end
    end
    busy_next  = busy;
    level_next = level;
    if (produce) begin
      busy_next  = (res.kind == gptw_pkg::KIND_REQ);
      level_next = (res.kind == gptw_pkg::KIND_REQ) ? res.walk_level : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      level     <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy  <= busy_next;
        level <= level_next;
        held  <= held_next;
      end
      out_valid <= (q_pop && produce) || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && produce) begin
      out_res <= res;
    end
  end

  `ASSERT_IMPL(a_busy_level, clk, rst, busy, level != '0 && level <= gptw_pkg::LEVEL_MAX,
               "walk busy with a level out of range")
  `ASSERT_IMPL(a_idle_level, clk, rst, !busy, level == '0, "idle walker holds a level")
  `ASSERT_NEXT(a_req_busy, clk, rst, q_pop && produce && res.kind == gptw_pkg::KIND_REQ,
               busy && level == $past(res.walk_level), "request issued without a pending walk")

endmodule
